@@ sv/drbl_pkg.sv @@
`default_nettype none
package drbl_pkg;

  localparam int unsigned NUM_BANKS = 16;
  localparam int unsigned ROW_BYTES = 1024;
  localparam int unsigned ADDR_BITS = 48;

  localparam int unsigned ROW_LOG2 = $clog2(ROW_BYTES);
  localparam int unsigned BANK_W   = $clog2(NUM_BANKS);
  localparam int unsigned ROW_W    = ADDR_BITS - BANK_W;

  localparam int unsigned LAT_W    = 10;
  localparam int unsigned LSL_W    = 4;
  localparam int unsigned DELAY_W  = 12;
  localparam int unsigned CNT_W    = 40;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned BIDX_W   = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE_LOG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LAT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_T_ACTIVATE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_T_CAS         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_T_PRECHARGE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_T_BUS         = 3'd6;

  localparam logic [LSL_W-1:0] RST_LINE_SIZE_LOG = 4'd6;
  localparam logic [LAT_W-1:0] RST_FIXED_LAT     = 10'd100;
  localparam logic [LAT_W-1:0] RST_T_ACTIVATE    = 10'd45;
  localparam logic [LAT_W-1:0] RST_T_CAS         = 10'd45;
  localparam logic [LAT_W-1:0] RST_T_PRECHARGE   = 10'd45;
  localparam logic [LAT_W-1:0] RST_T_BUS         = 10'd10;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic             fixed_mode;
    logic [LSL_W-1:0] line_size_log2;
    logic [LAT_W-1:0] fixed_latency;
    logic [LAT_W-1:0] t_activate;
    logic [LAT_W-1:0] t_cas;
    logic [LAT_W-1:0] t_precharge;
    logic [LAT_W-1:0] t_bus;
  } cfg_t;

  typedef struct packed {
    logic              is_write;
    logic [BANK_W-1:0] bank;
    logic [ROW_W-1:0]  row;
  } req_t;

endpackage
`default_nettype wire

@@ sv/drbl_front.sv @@
`default_nettype none
module drbl_front (
  input  var drbl_pkg::cfg_t                      cfg_i,
  input  wire                                     in_valid_i,
  input  wire                                     cmd_i,
  input  wire  [47:0]                             line_addr_i,
  input  wire                                     queue_full_i,
  output logic                                    in_stall_o,
  output logic                                    push_o,
  output drbl_pkg::req_t                          push_req_o
);
  import drbl_pkg::*;

  logic [LSL_W-1:0]     shift;
  logic [ADDR_BITS-1:0] quot;

  // lines larger than a row give one line per row
  always_comb begin
    if (cfg_i.line_size_log2 >= LSL_W'(ROW_LOG2)) begin
      shift = '0;
    end else begin
      shift = LSL_W'(ROW_LOG2) - cfg_i.line_size_log2;
    end
    quot = ADDR_BITS'(line_addr_i) >> shift;
  end

  assign in_stall_o          = queue_full_i;
  assign push_o              = in_valid_i && !queue_full_i;
  assign push_req_o.is_write = cmd_i;
  assign push_req_o.bank     = quot[BANK_W-1:0];
  assign push_req_o.row      = quot[ADDR_BITS-1:BANK_W];

endmodule
`default_nettype wire

@@ sv/drbl_queue.sv @@
`default_nettype none
module drbl_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  var drbl_pkg::req_t   push_req_i,
  input  wire                  pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output drbl_pkg::req_t       head_o
);
  import drbl_pkg::*;

  req_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule
`default_nettype wire

@@ sv/drbl_back.sv @@
`default_nettype none
module drbl_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  var drbl_pkg::cfg_t   cfg_i,
  input  wire                  empty_i,
  input  var drbl_pkg::req_t   head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [11:0]          access_delay_o,
  output logic                 row_hit_o,
  output logic [3:0]           bank_index_o,
  output logic [39:0]          reads_total_o,
  output logic [39:0]          writes_total_o,
  output logic [47:0]          read_delay_sum_o,
  output logic [47:0]          write_delay_sum_o
);
  import drbl_pkg::*;

  logic [NUM_BANKS-1:0] open_valid_q;
  logic [ROW_W-1:0]     open_row_q [NUM_BANKS];

  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d, wr_cnt_q, wr_cnt_d;
  logic [SUM_W-1:0] rd_sum_q, rd_sum_d, wr_sum_q, wr_sum_d;

  logic               out_valid_q;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic               hit_q, hit_d;
  logic [BIDX_W-1:0]  bank_q;

  logic [DELAY_W-1:0] base_delay;
  logic [DELAY_W-1:0] miss_delay;
  logic               row_match;
  logic [CNT_W-1:0]   cnt_sel, cnt_inc;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sel, sum_new;

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    base_delay = DELAY_W'(cfg_i.t_cas) + DELAY_W'(cfg_i.t_bus);
    miss_delay = DELAY_W'(cfg_i.t_precharge) + DELAY_W'(cfg_i.t_activate);
    row_match  = open_valid_q[head_i.bank] && (open_row_q[head_i.bank] == head_i.row);
    if (cfg_i.fixed_mode) begin
      delay_d = DELAY_W'(cfg_i.fixed_latency);
      hit_d   = 1'b0;
    end else if (row_match && !head_i.is_write) begin
      delay_d = base_delay;
      hit_d   = 1'b1;
    end else begin
      delay_d = base_delay + miss_delay;
      hit_d   = 1'b0;
    end

    // saturating count and sum for the kind of this transaction
    cnt_sel = head_i.is_write ? wr_cnt_q : rd_cnt_q;
    sum_sel = head_i.is_write ? wr_sum_q : rd_sum_q;
    cnt_inc = (&cnt_sel) ? cnt_sel : cnt_sel + 1'b1;
    sum_add = {1'b0, sum_sel} + (SUM_W + 1)'(delay_d);
    sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    rd_cnt_d = rd_cnt_q;
    wr_cnt_d = wr_cnt_q;
    rd_sum_d = rd_sum_q;
    wr_sum_d = wr_sum_q;
    if (head_i.is_write) begin
      wr_cnt_d = cnt_inc;
      wr_sum_d = sum_new;
    end else begin
      rd_cnt_d = cnt_inc;
      rd_sum_d = sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_valid_q <= '0;
      rd_cnt_q     <= '0;
      wr_cnt_q     <= '0;
      rd_sum_q     <= '0;
      wr_sum_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        rd_cnt_q    <= rd_cnt_d;
        wr_cnt_q    <= wr_cnt_d;
        rd_sum_q    <= rd_sum_d;
        wr_sum_q    <= wr_sum_d;
        out_valid_q <= 1'b1;
        if (!cfg_i.fixed_mode) begin
          open_valid_q[head_i.bank] <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      delay_q <= delay_d;
      hit_q   <= hit_d;
      bank_q  <= BIDX_W'(head_i.bank);
      if (!cfg_i.fixed_mode) begin
        open_row_q[head_i.bank] <= head_i.row;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign access_delay_o    = delay_q;
  assign row_hit_o         = hit_q;
  assign bank_index_o      = bank_q;
  assign reads_total_o     = rd_cnt_q;
  assign writes_total_o    = wr_cnt_q;
  assign read_delay_sum_o  = rd_sum_q;
  assign write_delay_sum_o = wr_sum_q;

endmodule
`default_nettype wire

@@ sv/dram_row_buffer_latency.sv @@
`default_nettype none
// Open-page DRAM latency estimator. Each input transaction (read or write to a
// cache line address) is split into bank and row by the configured line size;
// the front end classifies it and pushes it into a two-entry queue, the back
// end looks up the per-bank open row, works out the latency, updates the row
// table and the saturating read/write statistics, and holds the result in an
// output register. One transaction per cycle is sustained while the output is
// not stalled; each transaction is written into the queue when it is taken and
// moves on through the back end's table lookup into the output register, which
// holds it while the output is stalled. Configuration registers may be written
// only while no transaction is in flight.
module dram_row_buffer_latency (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_idx_i,
  input  wire  [9:0]   cfg_wdata_i,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire          cmd_i,
  input  wire  [47:0]  line_addr_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output logic [11:0]  access_delay_o,
  output logic         row_hit_o,
  output logic [3:0]   bank_index_o,
  output logic [39:0]  reads_total_o,
  output logic [39:0]  writes_total_o,
  output logic [47:0]  read_delay_sum_o,
  output logic [47:0]  write_delay_sum_o
);
  import drbl_pkg::*;

  cfg_t cfg_q;
  logic push, pop, full, empty;
  req_t push_req, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fixed_mode     <= 1'b0;
      cfg_q.line_size_log2 <= RST_LINE_SIZE_LOG;
      cfg_q.fixed_latency  <= RST_FIXED_LAT;
      cfg_q.t_activate     <= RST_T_ACTIVATE;
      cfg_q.t_cas          <= RST_T_CAS;
      cfg_q.t_precharge    <= RST_T_PRECHARGE;
      cfg_q.t_bus          <= RST_T_BUS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIXED_MODE:    cfg_q.fixed_mode     <= cfg_wdata_i[0];
        CFG_LINE_SIZE_LOG: cfg_q.line_size_log2 <= cfg_wdata_i[LSL_W-1:0];
        CFG_FIXED_LAT:     cfg_q.fixed_latency  <= cfg_wdata_i;
        CFG_T_ACTIVATE:    cfg_q.t_activate     <= cfg_wdata_i;
        CFG_T_CAS:         cfg_q.t_cas          <= cfg_wdata_i;
        CFG_T_PRECHARGE:   cfg_q.t_precharge    <= cfg_wdata_i;
        CFG_T_BUS:         cfg_q.t_bus          <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  drbl_front u_front (
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .cmd_i        (cmd_i),
    .line_addr_i  (line_addr_i),
    .queue_full_i (full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .push_req_o   (push_req)
  );

  drbl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head)
  );

  drbl_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .empty_i           (empty),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .access_delay_o    (access_delay_o),
    .row_hit_o         (row_hit_o),
    .bank_index_o      (bank_index_o),
    .reads_total_o     (reads_total_o),
    .writes_total_o    (writes_total_o),
    .read_delay_sum_o  (read_delay_sum_o),
    .write_delay_sum_o (write_delay_sum_o)
  );

endmodule
`default_nettype wire

@@ dv/dram_latency_checker.sv @@
`timescale 1ns / 100ps
module dram_latency_checker (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_idx_i,
  input  wire  [9:0]   cfg_wdata_i,
  input  wire          in_valid_i,
  input  wire          in_stall_i,
  input  wire          cmd_i,
  input  wire  [47:0]  line_addr_i,
  input  wire          out_valid_i,
  input  wire          out_stall_i,
  input  wire  [11:0]  access_delay_i,
  input  wire          row_hit_i,
  input  wire  [3:0]   bank_index_i,
  input  wire  [39:0]  reads_total_i,
  input  wire  [39:0]  writes_total_i,
  input  wire  [47:0]  read_delay_sum_i,
  input  wire  [47:0]  write_delay_sum_i,
  output int           mismatch_cnt_o,
  output int           outstanding_o,
  output int           row_hits_o
);
  import drbl_pkg::*;

  localparam logic [63:0] CNT_LIMIT = (64'd1 << CNT_W) - 64'd1;
  localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               hit;
    logic [BIDX_W-1:0]  bank;
    logic [CNT_W-1:0]   reads;
    logic [CNT_W-1:0]   writes;
    logic [SUM_W-1:0]   rd_sum;
    logic [SUM_W-1:0]   wr_sum;
  } access_result_t;

  cfg_t                  cfg_q;
  logic [NUM_BANKS-1:0]  bank_open_q;
  logic [ROW_W-1:0]      bank_row_q [NUM_BANKS];
  logic [CNT_W-1:0]      read_cnt_q;
  logic [CNT_W-1:0]      write_cnt_q;
  logic [SUM_W-1:0]      read_acc_q;
  logic [SUM_W-1:0]      write_acc_q;

  access_result_t        latency_q [$];
  int                    mismatches;
  int                    results_seen;

  assign mismatch_cnt_o = mismatches;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] limit);
    if (a >= limit || b > limit - a) return limit;
    return a + b;
  endfunction

  task automatic model_access(input logic is_wr, input logic [47:0] addr,
                              output access_result_t res);
    int unsigned       sh;
    logic [47:0]       quot;
    logic [BANK_W-1:0] bank;
    logic [ROW_W-1:0]  row;
    logic [DELAY_W-1:0] delay;
    logic              hit;
    sh    = (cfg_q.line_size_log2 >= ROW_LOG2) ? 0 : ROW_LOG2 - cfg_q.line_size_log2;
    quot  = addr >> sh;
    bank  = quot[BANK_W-1:0];
    row   = quot[47:BANK_W];
    hit   = 1'b0;
    if (cfg_q.fixed_mode) begin
      delay = DELAY_W'(cfg_q.fixed_latency);
    end else begin
      delay = DELAY_W'(cfg_q.t_cas) + DELAY_W'(cfg_q.t_bus);
      // writes always reopen the row
      if (!bank_open_q[bank] || bank_row_q[bank] != row || is_wr) begin
        delay = delay + DELAY_W'(cfg_q.t_precharge) + DELAY_W'(cfg_q.t_activate);
      end else begin
        hit = 1'b1;
      end
      bank_row_q[bank]  = row;
      bank_open_q[bank] = 1'b1;
    end
    if (is_wr) begin
      write_cnt_q = CNT_W'(sat_add(64'(write_cnt_q), 64'd1, CNT_LIMIT));
      write_acc_q = SUM_W'(sat_add(64'(write_acc_q), 64'(delay), SUM_LIMIT));
    end else begin
      read_cnt_q = CNT_W'(sat_add(64'(read_cnt_q), 64'd1, CNT_LIMIT));
      read_acc_q = SUM_W'(sat_add(64'(read_acc_q), 64'(delay), SUM_LIMIT));
    end
    res.delay  = delay;
    res.hit    = hit;
    res.bank   = bank;
    res.reads  = read_cnt_q;
    res.writes = write_cnt_q;
    res.rd_sum = read_acc_q;
    res.wr_sum = write_acc_q;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result %0d %s mismatch: expected %0h, got %0h",
                 $time, results_seen, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    access_result_t want;
    access_result_t fresh;
    if (!rst_ni) begin
      cfg_q = '{fixed_mode: 1'b0, line_size_log2: RST_LINE_SIZE_LOG,
                fixed_latency: RST_FIXED_LAT, t_activate: RST_T_ACTIVATE,
                t_cas: RST_T_CAS, t_precharge: RST_T_PRECHARGE, t_bus: RST_T_BUS};
      bank_open_q   = '0;
      read_cnt_q    = '0;
      write_cnt_q   = '0;
      read_acc_q    = '0;
      write_acc_q   = '0;
      latency_q.delete();
      mismatches    = 0;
      results_seen  = 0;
      row_hits_o    <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIXED_MODE:    cfg_q.fixed_mode     = cfg_wdata_i[0];
          CFG_LINE_SIZE_LOG: cfg_q.line_size_log2 = cfg_wdata_i[LSL_W-1:0];
          CFG_FIXED_LAT:     cfg_q.fixed_latency  = cfg_wdata_i;
          CFG_T_ACTIVATE:    cfg_q.t_activate     = cfg_wdata_i;
          CFG_T_CAS:         cfg_q.t_cas          = cfg_wdata_i;
          CFG_T_PRECHARGE:   cfg_q.t_precharge    = cfg_wdata_i;
          CFG_T_BUS:         cfg_q.t_bus          = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (latency_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d arrived with no transaction outstanding",
                     $time, results_seen);
          end
        end else begin
          want = latency_q.pop_front();
          check_field("access_delay",    64'(want.delay),  64'(access_delay_i));
          check_field("row_hit",         64'(want.hit),    64'(row_hit_i));
          check_field("bank_index",      64'(want.bank),   64'(bank_index_i));
          check_field("reads_total",     64'(want.reads),  64'(reads_total_i));
          check_field("writes_total",    64'(want.writes), 64'(writes_total_i));
          check_field("read_delay_sum",  64'(want.rd_sum), 64'(read_delay_sum_i));
          check_field("write_delay_sum", 64'(want.wr_sum), 64'(write_delay_sum_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        model_access(cmd_i, line_addr_i, fresh);
        latency_q.push_back(fresh);
        if (fresh.hit) row_hits_o <= row_hits_o + 1;
      end
      outstanding_o <= latency_q.size();
    end
  end

endmodule

@@ dv/dram_row_buffer_latency_test.sv @@
`timescale 1ns / 100ps
module dram_row_buffer_latency_test;
  import drbl_pkg::*;

  localparam int CYCLE_LIMIT    = 300000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 153;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  cmd       = 1'b0;
  logic [47:0]           line_addr = '0;
  logic                  out_stall = 1'b1;

  wire                   in_stall;
  wire                   out_valid;
  wire  [11:0]           access_delay;
  wire                   row_hit;
  wire  [3:0]            bank_index;
  wire  [39:0]           reads_total;
  wire  [39:0]           writes_total;
  wire  [47:0]           read_delay_sum;
  wire  [47:0]           write_delay_sum;

  int                    mismatches;
  int                    outstanding;
  int                    row_hits;
  int                    sent_cnt   = 0;
  int                    phase_cnt  = 0;
  int                    cycle_cnt  = 0;
  cfg_t                  tb_cfg;
  logic [47:0]           recent_addr [$];

  dram_row_buffer_latency u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .cmd_i            (cmd),
    .line_addr_i      (line_addr),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .access_delay_o   (access_delay),
    .row_hit_o        (row_hit),
    .bank_index_o     (bank_index),
    .reads_total_o    (reads_total),
    .writes_total_o   (writes_total),
    .read_delay_sum_o (read_delay_sum),
    .write_delay_sum_o(write_delay_sum)
  );

  dram_latency_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .cmd_i            (cmd),
    .line_addr_i      (line_addr),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .access_delay_i   (access_delay),
    .row_hit_i        (row_hit),
    .bank_index_i     (bank_index),
    .reads_total_i    (reads_total),
    .writes_total_i   (writes_total),
    .read_delay_sum_i (read_delay_sum),
    .write_delay_sum_i(write_delay_sum),
    .mismatch_cnt_o   (mismatches),
    .outstanding_o    (outstanding),
    .row_hits_o       (row_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions still outstanding",
               cycle_cnt, outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall stretches plus two long hold-offs that back up the block
  initial begin : rx_side
    int pct;
    int left;
    int hold;
    int taken;
    int next_hold;
    pct       = 0;
    left      = 0;
    hold      = 0;
    taken     = 0;
    next_hold = 350;
    forever begin
      @(posedge clk);
      if (rst_n && in_valid && !in_stall) taken++;
      if (hold > 0) begin
        hold--;
      end else if (taken >= next_hold) begin
        hold      = 120;
        next_hold = next_hold + 600;
      end
      if (left == 0) begin
        left = $urandom_range(64, 8);
        case ($urandom_range(4))
          0, 1:    pct = 0;
          2:       pct = 30;
          3:       pct = 60;
          default: pct = 90;
        endcase
      end
      left--;
      out_stall <= (hold > 0) || ($urandom_range(99) < pct);
    end
  end

  task automatic offer_access(input logic is_wr, input logic [47:0] addr);
    in_valid  <= 1'b1;
    cmd       <= is_wr;
    line_addr <= addr;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  task automatic idle_input(input int cycles);
    in_valid      <= 1'b0;
    cmd           <= 1'($urandom);
    line_addr[47:32] <= 16'($urandom);
    line_addr[31:0]  <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // stop offering until every transaction has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic program_regs(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx [7];
    logic [CFG_DATA_W-1:0] val [7];
    idx = '{CFG_FIXED_MODE, CFG_LINE_SIZE_LOG, CFG_FIXED_LAT, CFG_T_ACTIVATE,
            CFG_T_CAS, CFG_T_PRECHARGE, CFG_T_BUS};
    val = '{CFG_DATA_W'(c.fixed_mode), CFG_DATA_W'(c.line_size_log2), c.fixed_latency,
            c.t_activate, c.t_cas, c.t_precharge, c.t_bus};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    tb_cfg = c;
    phase_cnt++;
  endtask

  function automatic logic [LAT_W-1:0] pick_timing();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return LAT_W'($urandom_range(1023));
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.fixed_mode     = ($urandom_range(4) == 0);
    c.line_size_log2 = LSL_W'($urandom_range(10));
    c.fixed_latency  = pick_timing();
    c.t_activate     = pick_timing();
    c.t_cas          = pick_timing();
    c.t_precharge    = pick_timing();
    c.t_bus          = pick_timing();
    return c;
  endfunction

  // mostly a few rows per bank so open rows get reused, some fully random addresses
  function automatic logic [47:0] pick_addr();
    int unsigned      sh;
    logic [47:0]      mask;
    logic [47:0]      noise;
    logic [47:0]      a;
    logic [ROW_W-1:0] row;
    logic [3:0]       bank;
    int               r;
    sh    = (tb_cfg.line_size_log2 >= ROW_LOG2) ? 0 : ROW_LOG2 - tb_cfg.line_size_log2;
    mask  = (48'd1 << sh) - 48'd1;
    noise = 48'({$urandom, $urandom});
    r     = $urandom_range(99);
    if (r < 10) begin
      a = noise;
    end else if (r < 45 && recent_addr.size() > 0) begin
      a = recent_addr[$urandom_range(recent_addr.size() - 1)] ^ (noise & mask);
    end else begin
      row  = ROW_W'($urandom_range(3));
      if ($urandom_range(9) == 0) row = ROW_W'({$urandom, $urandom});
      bank = 4'($urandom_range(15));
      a    = ({row, bank} << sh) | (noise & mask);
    end
    recent_addr.push_back(a);
    if (recent_addr.size() > 8) void'(recent_addr.pop_front());
    return a;
  endfunction

  initial begin : stimulus
    int remaining;
    int burst;
    int gap;
    bit dense;
    tb_cfg = '{fixed_mode: 1'b0, line_size_log2: RST_LINE_SIZE_LOG,
               fixed_latency: RST_FIXED_LAT, t_activate: RST_T_ACTIVATE,
               t_cas: RST_T_CAS, t_precharge: RST_T_PRECHARGE, t_bus: RST_T_BUS};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 16 lines per row, bank = addr[7:4]
    offer_access(1'b0, 48'h0);              // empty bank
    offer_access(1'b0, 48'h0);              // open row hit
    offer_access(1'b0, 48'hF);              // other line, same row
    offer_access(1'b1, 48'h0);              // write never hits
    offer_access(1'b0, 48'h0);              // row left open by the write
    offer_access(1'b0, 48'h100);            // row conflict in bank 0
    offer_access(1'b0, 48'h0);
    offer_access(1'b0, 48'hFFFF_FFFF_FFFF);
    offer_access(1'b0, 48'hFFFF_FFFF_FFFF);
    offer_access(1'b1, 48'hFFFF_FFFF_FFFF);
    offer_access(1'b0, 48'h10);
    offer_access(1'b0, 48'h8000_0000_0000);
    drain();

    // zero timings, one byte lines
    program_regs('{fixed_mode: 1'b0, line_size_log2: '0, fixed_latency: '0,
                   t_activate: '0, t_cas: '0, t_precharge: '0, t_bus: '0});
    offer_access(1'b0, 48'h3FF);
    offer_access(1'b1, 48'h0);
    drain();

    // largest timings, line as big as a row: shift is zero
    program_regs('{fixed_mode: 1'b0, line_size_log2: LSL_W'(10), fixed_latency: '1,
                   t_activate: '1, t_cas: '1, t_precharge: '1, t_bus: '1});
    offer_access(1'b0, 48'h5);
    offer_access(1'b0, 48'h5);
    offer_access(1'b1, 48'h5);
    offer_access(1'b0, 48'hFFFF_FFFF_FFFF);
    drain();

    program_regs('{fixed_mode: 1'b1, line_size_log2: LSL_W'(3), fixed_latency: '1,
                   t_activate: '0, t_cas: '0, t_precharge: '0, t_bus: '0});
    offer_access(1'b0, 48'h1234_5678_9ABC);
    offer_access(1'b1, 48'hFFFF_FFFF_FFFF);
    drain();
    program_regs('{fixed_mode: 1'b1, line_size_log2: LSL_W'(6), fixed_latency: '0,
                   t_activate: '1, t_cas: '1, t_precharge: '1, t_bus: '1});
    offer_access(1'b0, 48'h5);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_regs(random_cfg());
      recent_addr.delete();
      dense     = (p == 2);
      remaining = PHASE_ITEMS;
      while (remaining > 0) begin
        burst = $urandom_range(24, 1);
        if (burst > remaining) burst = remaining;
        repeat (burst) offer_access(($urandom_range(9) < 3), pick_addr());
        remaining -= burst;
        if (!dense) begin
          gap = $urandom_range(6);
          if (gap > 0) idle_input(gap);
          if ($urandom_range(30) == 0) drain();
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("ran %0d accesses (%0d open row hits) across %0d register settings",
             sent_cnt, row_hits, phase_cnt);
    $display("zero and full timings, fixed latency mode, all line sizes, two output hold-offs");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ dram_row_buffer_latency.f @@
sv/drbl_pkg.sv
sv/drbl_front.sv
sv/drbl_queue.sv
sv/drbl_back.sv
sv/dram_row_buffer_latency.sv
dv/dram_latency_checker.sv
dv/dram_row_buffer_latency_test.sv
